[rtl/stack_machine_execute_unit_defines.svh]
// assertion macros shared by the execute unit rtl
// no dependencies; included by files that carry concurrent checks
`ifndef STACK_MACHINE_EXECUTE_UNIT_DEFINES_SVH
`define STACK_MACHINE_EXECUTE_UNIT_DEFINES_SVH

// same-cycle implication
`define SMEU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SMEU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/smeu_pkg.sv]
// shared constants, codes and controller/datapath interface types
// no dependencies
`timescale 1ns / 1ps

package smeu_pkg;

    localparam int DATA_DEPTH   = 64;
    localparam int CALL_DEPTH   = 16;
    localparam int AUX_BASE     = 16;
    localparam int AUX_WINDOW   = 8;
    localparam int AUX_DEPTH    = 256;
    localparam int GLOBAL_DEPTH = 256;

    localparam int DA_W = $clog2(DATA_DEPTH);
    localparam int DC_W = $clog2(DATA_DEPTH + 1);
    localparam int FA_W = $clog2(CALL_DEPTH);
    localparam int FC_W = $clog2(CALL_DEPTH + 1);
    localparam int AA_W = $clog2(AUX_DEPTH);
    localparam int AF_W = $clog2(AUX_DEPTH + 1);
    localparam int GA_W = $clog2(GLOBAL_DEPTH);
    localparam int K_W  = $clog2(((AUX_WINDOW > 3) ? AUX_WINDOW : 3) + 1);

    localparam int AUX_FRONT_RST = (AUX_BASE >= AUX_DEPTH) ? 0 : AUX_DEPTH - AUX_BASE;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 96;
    localparam int OUT_TUSER_W = 2;

    localparam logic [7:0] OP_TRAP = 8'h00;
    localparam logic [7:0] OP_EXIT = 8'h01;
    localparam logic [7:0] OP_PRN  = 8'h03;
    localparam logic [7:0] OP_PRC  = 8'h04;
    localparam logic [7:0] OP_NOP  = 8'h10;
    localparam logic [7:0] OP_ADD  = 8'h11;
    localparam logic [7:0] OP_SUB  = 8'h12;
    localparam logic [7:0] OP_MUL  = 8'h13;
    localparam logic [7:0] OP_DIV  = 8'h14;
    localparam logic [7:0] OP_MOD  = 8'h15;
    localparam logic [7:0] OP_SHL  = 8'h16;
    localparam logic [7:0] OP_SHR  = 8'h17;
    localparam logic [7:0] OP_SAR  = 8'h18;
    localparam logic [7:0] OP_AND  = 8'h19;
    localparam logic [7:0] OP_OR   = 8'h1A;
    localparam logic [7:0] OP_LNOT = 8'h20;
    localparam logic [7:0] OP_NOT  = 8'h21;
    localparam logic [7:0] OP_NEG  = 8'h22;
    localparam logic [7:0] OP_IMM  = 8'h40;
    localparam logic [7:0] OP_GLD  = 8'h43;
    localparam logic [7:0] OP_GST  = 8'h44;
    localparam logic [7:0] OP_GBI  = 8'h45;
    localparam logic [7:0] OP_AST  = 8'h46;
    localparam logic [7:0] OP_ALD  = 8'h47;
    localparam logic [7:0] OP_AMV  = 8'h48;
    localparam logic [7:0] OP_DUP  = 8'h60;
    localparam logic [7:0] OP_DUP2 = 8'h61;
    localparam logic [7:0] OP_ROT2 = 8'h62;
    localparam logic [7:0] OP_ROT3 = 8'h63;
    localparam logic [7:0] OP_DROP = 8'h64;
    localparam logic [7:0] OP_JMP  = 8'h70;
    localparam logic [7:0] OP_JNZ  = 8'h71;
    localparam logic [7:0] OP_CALL = 8'h72;
    localparam logic [7:0] OP_RET  = 8'h73;

    typedef enum logic [3:0] {
        ST_OK    = 4'd0,
        ST_EXIT  = 4'd1,
        ST_TRAP  = 4'd2,
        ST_BADOP = 4'd3,
        ST_UNDER = 4'd4,
        ST_OVER  = 4'd5,
        ST_DIVZ  = 4'd6,
        ST_CALL  = 4'd7,
        ST_INDEX = 4'd8
    } t_status;

    typedef enum logic [1:0] {
        KD_NONE = 2'd0,
        KD_DEC  = 2'd1,
        KD_CHAR = 2'd2,
        KD_EXIT = 2'd3
    } t_kind;

    typedef struct packed {
        logic [15:0] pc;
        logic [7:0]  chunk;
        logic [8:0]  base;
    } t_frame;

    typedef struct packed {
        logic           load;
        logic           chk;
        logic           rd_en;
        logic           rd_cap;
        logic           alu;
        logic           mdu_start;
        logic           mdu_cap;
        logic           wr_en;
        logic           clr_en;
        logic           commit;
        logic           out_load;
        logic [K_W-1:0] k;
    } t_cmd;

    typedef struct packed {
        logic       chk_fault;
        logic       alu_fault;
        logic       use_mdu;
        logic       mdu_done;
        logic       is_call;
        logic       out_free;
        logic [1:0] nrd;
        logic [1:0] nwr;
    } t_sts;

endpackage

[rtl/stack_machine_execute_unit.sv]
// An item with no data stack access passes through accept, check, alu, commit and
// result load. Data stack reads are issued one at a time in the read state, each read
// word being registered before it is captured, and stack writes are made one at a time
// in the write state. Multiply waits on the 32x32 multiplier and divide and modulo on
// the bit-serial divider of the shared multiply/divide unit, and call zeroes the new
// aux window one entry at a time. An item that faults at the check, or arrives while
// halted, skips the stack reads and the alu.
// The result load waits while the output register still holds an unaccepted beat.
// The next item is taken while the previous result waits in the output register.
// top level: joins smeu_ctrl and smeu_dpath; depends on smeu_pkg
`timescale 1ns / 1ps

module stack_machine_execute_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // opcode[7:0], param[15:8]
    input  logic [smeu_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // status[3:0], next_pc[19:4], chunk[27:20], out_value[91:28], zero pad
    output logic [smeu_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // out_kind[1:0]
    output logic [smeu_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
    import smeu_pkg::*;

    t_cmd cmd;
    t_sts sts;

    smeu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    smeu_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_tdata     (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser)
    );

endmodule

[rtl/smeu_mdu.sv]
// shared multiply/divide unit: three 32x32 partial products or 64 restoring steps
// depends on the assertion macros
`timescale 1ns / 1ps
`include "stack_machine_execute_unit_defines.svh"

module smeu_mdu (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_div,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_prod,
    output logic [63:0] o_quo,
    output logic [63:0] o_rem
);
    logic        r_busy;
    logic        r_div;
    logic        r_done;
    logic [5:0]  r_n;
    logic [63:0] r_x;
    logic [63:0] r_y;
    logic [63:0] r_acc;
    logic [63:0] r_rem;
    logic        r_negq;
    logic        r_negr;

    logic [31:0] mx;
    logic [31:0] my;
    logic [63:0] prod;
    logic [63:0] addend;
    logic [64:0] t;
    logic [64:0] diff;
    logic        ge;

    always_comb begin
        mx     = (r_n == 6'd2) ? r_y[63:32] : r_y[31:0];
        my     = (r_n == 6'd1) ? r_x[63:32] : r_x[31:0];
        prod   = mx * my;
        addend = (r_n == 6'd0) ? prod : {prod[31:0], 32'd0};
        t      = {r_rem, r_x[63]};
        diff   = t - {1'b0, r_y};
        ge     = (t >= {1'b0, r_y});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_n    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_n    <= '0;
            end else if (r_busy) begin
                r_n <= r_n + 6'd1;
                if ((!r_div && r_n == 6'd2) || (r_div && r_n == 6'd63)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div  <= i_div;
            r_acc  <= '0;
            r_rem  <= '0;
            r_negq <= i_b[63] ^ i_a[63];
            r_negr <= i_b[63];
            if (i_div) begin
                r_x <= i_b[63] ? (64'd0 - i_b) : i_b;
                r_y <= i_a[63] ? (64'd0 - i_a) : i_a;
            end else begin
                r_x <= i_b;
                r_y <= i_a;
            end
        end else if (r_busy) begin
            if (r_div) begin
                r_rem <= ge ? diff[63:0] : t[63:0];
                r_x   <= {r_x[62:0], ge};
            end else begin
                r_acc <= r_acc + addend;
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
    assign o_quo  = r_negq ? (64'd0 - r_x) : r_x;
    assign o_rem  = r_negr ? (64'd0 - r_rem) : r_rem;

    `SMEU_ASSERT_IMP(a_start_when_idle, i_clk, i_rst_n, i_start, !r_busy, "mdu started while busy")
    `SMEU_ASSERT_NXT(a_done_pulse, i_clk, i_rst_n, r_done, !r_done, "mdu done held two cycles")

endmodule

[rtl/smeu_dpath.sv]
// datapath: data stack, frame store, aux and global stores, alu, result register
// depends on smeu_pkg, smeu_mdu and the assertion macros
`timescale 1ns / 1ps
`include "stack_machine_execute_unit_defines.svh"

module smeu_dpath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  smeu_pkg::t_cmd                   i_cmd,
    output smeu_pkg::t_sts                   o_sts,
    input  logic [smeu_pkg::IN_TDATA_W-1:0]  i_tdata,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [smeu_pkg::OUT_TDATA_W-1:0] o_out_data,
    output logic [smeu_pkg::OUT_TUSER_W-1:0] o_out_user
);
    import smeu_pkg::*;

    logic [63:0] r_dmem [DATA_DEPTH];
    logic [63:0] r_amem [AUX_DEPTH];
    logic [63:0] r_gmem [GLOBAL_DEPTH];
    logic [AUX_DEPTH-1:0]    r_aval;
    logic [GLOBAL_DEPTH-1:0] r_gval;
    t_frame      r_frames [CALL_DEPTH];

    logic [7:0]      r_op;
    logic [7:0]      r_param;
    logic [DC_W-1:0] r_cnt;
    logic [FC_W-1:0] r_fcnt;
    logic [AF_W-1:0] r_front;
    logic [15:0]     r_pc;
    logic [7:0]      r_chunk;
    logic [8:0]      r_gbase;
    logic            r_halt;
    t_status         r_hcode;
    t_status         r_st;
    t_kind           r_kind;
    logic [63:0]     r_val;
    logic [63:0]     r_dq;
    logic [63:0]     r_a;
    logic [63:0]     r_b;
    logic [63:0]     r_c;
    logic [63:0]     r_res;
    logic [63:0]     r_aq;
    logic            r_av;
    logic [63:0]     r_gq;
    logic            r_gv;
    logic            r_ovalid;
    logic [OUT_TDATA_W-1:0] r_odata;
    logic [OUT_TUSER_W-1:0] r_ouser;

    logic [63:0]     imm;
    logic [15:0]     pc_rel;
    logic [10:0]     gidx;
    logic            g_ok;
    logic [GA_W-1:0] g_addr;
    logic [AF_W-1:0] aux_size;
    logic            a_ok;
    logic [AA_W-1:0] a_addr;
    logic [AA_W-1:0] c_addr;
    t_frame          top_frame;
    logic [2:0]      need;
    logic [2:0]      push;
    logic [1:0]      nrd;
    logic [1:0]      nwr;
    t_status         chk_st;
    logic [63:0]     alu_res;
    t_status         alu_st;
    t_kind           alu_kind;
    logic [63:0]     alu_val;
    logic            divop;
    logic            a_zero;
    logic [DA_W-1:0] rd_addr;
    logic [2:0]      wr_u;
    logic [63:0]     wr_data;
    logic [DA_W-1:0] wr_addr;
    logic [1:0]      cnt_du;
    logic [63:0]     aux_rd;
    logic [63:0]     glb_rd;
    logic            mdu_done;
    logic [63:0]     mdu_prod;
    logic [63:0]     mdu_quo;
    logic [63:0]     mdu_rem;

    function automatic t_status f_room(input logic [DC_W-1:0] cnt, input logic [2:0] nd,
                                       input logic [2:0] ps);
        logic [DC_W:0] after;
        after = (DC_W+1)'(cnt) + (DC_W+1)'(ps) - (DC_W+1)'(nd);
        if (cnt < DC_W'(nd)) return ST_UNDER;
        if (after > (DC_W+1)'(DATA_DEPTH)) return ST_OVER;
        return ST_OK;
    endfunction

    always_comb begin
        imm       = {{56{r_param[7]}}, r_param};
        pc_rel    = r_pc + {{8{r_param[7]}}, r_param};
        gidx      = {{2{r_gbase[8]}}, r_gbase} + {{3{r_param[7]}}, r_param};
        g_ok      = !gidx[10] && ({22'd0, gidx[9:0]} < 32'(GLOBAL_DEPTH));
        g_addr    = GA_W'(gidx[9:0]);
        aux_size  = AF_W'(AUX_DEPTH) - r_front;
        a_ok      = 16'(r_param) < 16'(aux_size);
        a_addr    = AA_W'(16'(r_front) + 16'(r_param));
        c_addr    = AA_W'(16'(r_front) - 16'(AUX_WINDOW) + 16'(i_cmd.k));
        top_frame = r_frames[FA_W'(r_fcnt - FC_W'(1))];
        aux_rd    = r_av ? r_aq : 64'd0;
        glb_rd    = r_gv ? r_gq : 64'd0;
    end

    // per-opcode stack needs and counts
    always_comb begin
        need = 3'd0;
        push = 3'd0;
        nrd  = 2'd0;
        nwr  = 2'd0;
        case (r_op)
            OP_EXIT: begin
                need = 3'd1; push = 3'd1; nrd = 2'd1;
            end
            OP_PRN, OP_PRC, OP_GST, OP_AST, OP_DROP, OP_JNZ: begin
                need = 3'd1; nrd = 2'd1;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_SHL, OP_SHR, OP_SAR, OP_AND,
            OP_OR: begin
                need = 3'd2; push = 3'd1; nrd = 2'd2; nwr = 2'd1;
            end
            OP_LNOT, OP_NOT, OP_NEG: begin
                need = 3'd1; push = 3'd1; nrd = 2'd1; nwr = 2'd1;
            end
            OP_IMM, OP_GLD, OP_ALD, OP_AMV: begin
                push = 3'd1; nwr = 2'd1;
            end
            OP_DUP: begin
                need = 3'd1; push = 3'd2; nrd = 2'd1; nwr = 2'd1;
            end
            OP_DUP2: begin
                need = 3'd2; push = 3'd4; nrd = 2'd2; nwr = 2'd2;
            end
            OP_ROT2: begin
                need = 3'd2; push = 3'd2; nrd = 2'd2; nwr = 2'd2;
            end
            OP_ROT3: begin
                need = 3'd3; push = 3'd3; nrd = 2'd3; nwr = 2'd3;
            end
            default: begin
                need = 3'd0;
            end
        endcase
    end

    always_comb begin
        chk_st = f_room(r_cnt, need, push);
        if (r_halt) begin
            chk_st = r_hcode;
        end else begin
            case (r_op)
                OP_TRAP: chk_st = ST_TRAP;
                OP_EXIT, OP_PRN, OP_PRC, OP_NOP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
                OP_SHL, OP_SHR, OP_SAR, OP_AND, OP_OR, OP_LNOT, OP_NOT, OP_NEG, OP_IMM,
                OP_GBI, OP_DUP, OP_DUP2, OP_ROT2, OP_ROT3, OP_DROP, OP_JMP, OP_JNZ: begin
                    chk_st = f_room(r_cnt, need, push);
                end
                OP_GLD, OP_GST: begin
                    if (chk_st == ST_OK && !g_ok) chk_st = ST_INDEX;
                end
                OP_AST, OP_ALD, OP_AMV: begin
                    if (chk_st == ST_OK && !a_ok) chk_st = ST_INDEX;
                end
                OP_CALL: begin
                    chk_st = (r_fcnt >= FC_W'(CALL_DEPTH) || 16'(r_front) < 16'(AUX_WINDOW))
                             ? ST_CALL : ST_OK;
                end
                OP_RET: begin
                    chk_st = (r_fcnt == '0) ? ST_CALL : ST_OK;
                end
                default: chk_st = ST_BADOP;
            endcase
        end
    end

    always_comb begin
        divop    = (r_op == OP_DIV) || (r_op == OP_MOD);
        a_zero   = (r_a == 64'd0);
        alu_st   = r_st;
        alu_kind = KD_NONE;
        alu_val  = 64'd0;
        case (r_op)
            OP_ADD:  alu_res = r_b + r_a;
            OP_SUB:  alu_res = r_b - r_a;
            OP_SHL:  alu_res = r_b << r_a[5:0];
            OP_SHR:  alu_res = r_b >> r_a[5:0];
            OP_SAR:  alu_res = $unsigned($signed(r_b) >>> r_a[5:0]);
            OP_AND:  alu_res = r_b & r_a;
            OP_OR:   alu_res = r_b | r_a;
            OP_LNOT: alu_res = {63'd0, a_zero};
            OP_NOT:  alu_res = ~r_a;
            OP_NEG:  alu_res = 64'd0 - r_a;
            default: alu_res = 64'd0;
        endcase
        case (r_op)
            OP_EXIT: begin
                alu_st = ST_EXIT; alu_kind = KD_EXIT; alu_val = r_a;
            end
            OP_PRN: begin
                alu_kind = KD_DEC; alu_val = r_a;
            end
            OP_PRC: begin
                alu_kind = KD_CHAR; alu_val = {56'd0, r_a[7:0]};
            end
            OP_DIV, OP_MOD: begin
                if (a_zero) alu_st = ST_DIVZ;
            end
            default: alu_kind = KD_NONE;
        endcase
    end

    // data stack write slots, offset relative to count minus three
    always_comb begin
        wr_u    = 3'd3;
        wr_data = r_res;
        case (r_op)
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_SHL, OP_SHR, OP_SAR, OP_AND,
            OP_OR: wr_u = 3'd1;
            OP_LNOT, OP_NOT, OP_NEG: wr_u = 3'd2;
            OP_IMM: wr_data = imm;
            OP_GLD: wr_data = glb_rd;
            OP_ALD, OP_AMV: wr_data = aux_rd;
            OP_DUP: wr_data = r_a;
            OP_DUP2: begin
                wr_u    = (i_cmd.k == '0) ? 3'd3 : 3'd4;
                wr_data = (i_cmd.k == '0) ? r_b : r_a;
            end
            OP_ROT2: begin
                wr_u    = (i_cmd.k == '0) ? 3'd2 : 3'd1;
                wr_data = (i_cmd.k == '0) ? r_b : r_a;
            end
            OP_ROT3: begin
                wr_u    = 3'(i_cmd.k);
                wr_data = (i_cmd.k == '0) ? r_b : ((i_cmd.k == K_W'(1)) ? r_a : r_c);
            end
            default: wr_u = 3'd3;
        endcase
        wr_addr = DA_W'(r_cnt + DC_W'(wr_u) - DC_W'(3));
        rd_addr = DA_W'(r_cnt - DC_W'(i_cmd.k) - DC_W'(1));
    end

    always_comb begin
        case (r_op)
            OP_PRN, OP_PRC, OP_GST, OP_AST, OP_DROP, OP_JNZ, OP_ADD, OP_SUB, OP_MUL,
            OP_DIV, OP_MOD, OP_SHL, OP_SHR, OP_SAR, OP_AND, OP_OR: cnt_du = 2'd0;
            OP_IMM, OP_GLD, OP_ALD, OP_AMV, OP_DUP: cnt_du = 2'd2;
            OP_DUP2: cnt_du = 2'd3;
            default: cnt_du = 2'd1;
        endcase
    end

    smeu_mdu u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mdu_start),
        .i_div   (divop),
        .i_a     (r_a),
        .i_b     (r_b),
        .o_done  (mdu_done),
        .o_prod  (mdu_prod),
        .o_quo   (mdu_quo),
        .o_rem   (mdu_rem)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) r_dq <= r_dmem[rd_addr];
        if (i_cmd.wr_en) r_dmem[wr_addr] <= wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.chk) begin
            r_aq <= r_amem[a_addr];
            r_gq <= r_gmem[g_addr];
        end
        if (i_cmd.clr_en) begin
            r_amem[c_addr] <= 64'd0;
        end else if (i_cmd.commit && r_st == ST_OK && r_op == OP_AST) begin
            r_amem[a_addr] <= r_a;
        end else if (i_cmd.commit && r_st == ST_OK && r_op == OP_AMV) begin
            r_amem[a_addr] <= 64'd0;
        end
        if (i_cmd.commit && r_st == ST_OK && r_op == OP_GST) r_gmem[g_addr] <= r_a;
        if (i_cmd.commit && r_st == ST_OK && r_op == OP_CALL) begin
            r_frames[FA_W'(r_fcnt)] <= '{pc: r_pc, chunk: r_chunk, base: r_gbase};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aval <= '0;
            r_gval <= '0;
        end else begin
            if (i_cmd.clr_en) r_aval[c_addr] <= 1'b1;
            else if (i_cmd.commit && r_st == ST_OK && (r_op == OP_AST || r_op == OP_AMV))
                r_aval[a_addr] <= 1'b1;
            if (i_cmd.commit && r_st == ST_OK && r_op == OP_GST) r_gval[g_addr] <= 1'b1;
            if (i_cmd.chk) begin
                r_av <= r_aval[a_addr];
                r_gv <= r_gval[g_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_tdata[7:0];
            r_param <= i_tdata[15:8];
            r_kind  <= KD_NONE;
            r_val   <= 64'd0;
        end
        if (i_cmd.rd_cap) begin
            if (i_cmd.k == K_W'(1)) r_a <= r_dq;
            else if (i_cmd.k == K_W'(2)) r_b <= r_dq;
            else r_c <= r_dq;
        end
        if (i_cmd.alu) begin
            r_res  <= alu_res;
            r_kind <= alu_kind;
            r_val  <= alu_val;
        end
        if (i_cmd.mdu_cap) begin
            r_res <= (r_op == OP_MUL) ? mdu_prod : ((r_op == OP_DIV) ? mdu_quo : mdu_rem);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_fcnt  <= '0;
            r_front <= AF_W'(AUX_FRONT_RST);
            r_pc    <= '0;
            r_chunk <= 8'd1;
            r_gbase <= '0;
            r_halt  <= 1'b0;
            r_hcode <= ST_OK;
            r_st    <= ST_OK;
        end else begin
            if (i_cmd.chk) r_st <= chk_st;
            if (i_cmd.alu) r_st <= alu_st;
            if (i_cmd.commit) begin
                if (r_st == ST_OK) begin
                    r_cnt <= r_cnt + DC_W'(cnt_du) - DC_W'(1);
                    r_pc  <= r_pc + 16'd1;
                    case (r_op)
                        OP_JMP: r_pc <= pc_rel;
                        OP_JNZ: if (r_a != 64'd0) r_pc <= pc_rel;
                        OP_GBI: r_gbase <= r_gbase + {r_param[7], r_param};
                        OP_CALL: begin
                            r_pc    <= '0;
                            r_chunk <= r_param;
                            r_gbase <= '0;
                            r_fcnt  <= r_fcnt + FC_W'(1);
                            r_front <= r_front - AF_W'(AUX_WINDOW);
                        end
                        OP_RET: begin
                            r_pc    <= top_frame.pc + 16'd1;
                            r_chunk <= top_frame.chunk;
                            r_gbase <= top_frame.base;
                            r_fcnt  <= r_fcnt - FC_W'(1);
                            r_front <= (16'(r_front) + 16'(AUX_WINDOW) > 16'(AUX_DEPTH))
                                       ? AF_W'(AUX_DEPTH) : r_front + AF_W'(AUX_WINDOW);
                        end
                        default: r_gbase <= r_gbase;
                    endcase
                end else begin
                    r_halt  <= 1'b1;
                    r_hcode <= r_st;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_odata <= {4'd0, r_val, r_chunk, r_pc, r_st};
            r_ouser <= r_kind;
        end
    end

    always_comb begin
        o_sts.chk_fault = (chk_st != ST_OK);
        o_sts.alu_fault = (alu_st == ST_DIVZ);
        o_sts.use_mdu   = (r_op == OP_MUL) || (divop && !a_zero);
        o_sts.mdu_done  = mdu_done;
        o_sts.is_call   = (r_op == OP_CALL);
        o_sts.out_free  = !r_ovalid || i_out_ready;
        o_sts.nrd       = nrd;
        o_sts.nwr       = nwr;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;
    assign o_out_user  = r_ouser;

    `SMEU_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= DC_W'(DATA_DEPTH), "data stack count past depth")
    `SMEU_ASSERT_IMP(a_fcnt_bound, i_clk, i_rst_n, 1'b1, r_fcnt <= FC_W'(CALL_DEPTH), "frame count past depth")
    `SMEU_ASSERT_IMP(a_halt_code, i_clk, i_rst_n, r_halt, r_hcode != ST_OK, "halted with ok code")

endmodule

[rtl/smeu_ctrl.sv]
// controller state machine: sequences check, stack reads, alu, mdu, writes, clear, commit and
// result load; depends on smeu_pkg and the assertion macros
`timescale 1ns / 1ps
`include "stack_machine_execute_unit_defines.svh"

module smeu_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  smeu_pkg::t_sts i_sts,
    output smeu_pkg::t_cmd o_cmd
);
    import smeu_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_CHK  = 9'b000000010,
        S_RD   = 9'b000000100,
        S_ALU  = 9'b000001000,
        S_MDW  = 9'b000010000,
        S_WR   = 9'b000100000,
        S_CLR  = 9'b001000000,
        S_CMT  = 9'b010000000,
        S_FIN  = 9'b100000000
    } t_state;

    t_state         r_state;
    t_state         n_state;
    logic [K_W-1:0] r_k;
    logic [K_W-1:0] n_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        o_cmd   = '0;
        o_cmd.k = r_k;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) n_state = S_CHK;
            end
            S_CHK: begin
                o_cmd.chk = 1'b1;
                n_k       = '0;
                if (i_sts.chk_fault) n_state = S_CMT;
                else if (i_sts.nrd != 2'd0) n_state = S_RD;
                else n_state = S_ALU;
            end
            S_RD: begin
                o_cmd.rd_en  = (r_k < K_W'(i_sts.nrd));
                o_cmd.rd_cap = (r_k != '0);
                n_k          = r_k + K_W'(1);
                if (r_k == K_W'(i_sts.nrd)) begin
                    n_state = S_ALU;
                    n_k     = '0;
                end
            end
            S_ALU: begin
                o_cmd.alu = 1'b1;
                n_k       = '0;
                if (i_sts.alu_fault) begin
                    n_state = S_CMT;
                end else if (i_sts.use_mdu) begin
                    o_cmd.mdu_start = 1'b1;
                    n_state         = S_MDW;
                end else if (i_sts.nwr != 2'd0) begin
                    n_state = S_WR;
                end else if (i_sts.is_call) begin
                    n_state = S_CLR;
                end else begin
                    n_state = S_CMT;
                end
            end
            S_MDW: begin
                if (i_sts.mdu_done) begin
                    o_cmd.mdu_cap = 1'b1;
                    n_state       = S_WR;
                end
            end
            S_WR: begin
                o_cmd.wr_en = 1'b1;
                n_k         = r_k + K_W'(1);
                if (r_k == K_W'(i_sts.nwr) - K_W'(1)) n_state = S_CMT;
            end
            S_CLR: begin
                o_cmd.clr_en = 1'b1;
                n_k          = r_k + K_W'(1);
                if (r_k == K_W'(AUX_WINDOW - 1)) n_state = S_CMT;
            end
            S_CMT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    `SMEU_ASSERT_IMP(a_done_in_wait, i_clk, i_rst_n, i_sts.mdu_done, r_state == S_MDW, "mdu result outside wait")
    `SMEU_ASSERT_NXT(a_commit_to_fin, i_clk, i_rst_n, r_state == S_CMT, r_state == S_FIN, "commit not followed by result")

endmodule

[verif/smeu_result_checker.sv]
// result checker for the stack machine execute unit: predicts every accepted
// instruction beat and compares each result beat with the oldest prediction
// depends on smeu_pkg
`timescale 1ns / 1ps

module smeu_result_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    input  logic [smeu_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    input  logic [smeu_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    input  logic [smeu_pkg::OUT_TUSER_W-1:0] i_m_tuser,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_depth,
    output int                               o_frames,
    output int                               o_aux_size,
    output logic [8:0]                       o_gbase,
    output logic [63:0]                      o_tos
);
    import smeu_pkg::*;

    typedef struct {
        t_status     status;
        logic [15:0] pc;
        logic [7:0]  chunk;
        t_kind       kind;
        logic [63:0] value;
    } t_outcome;

    t_outcome    outcome_q[$];
    logic [63:0] stk[DATA_DEPTH];
    t_frame      frm[CALL_DEPTH];
    logic [63:0] aux[AUX_DEPTH];
    logic [63:0] glb[GLOBAL_DEPTH];
    int          dcnt, fcnt, front;
    logic [15:0] pc;
    logic [7:0]  chunk;
    logic [8:0]  gbase;
    logic        halted;
    t_status     hcode;

    assign o_pending  = outcome_q.size();
    assign o_depth    = dcnt;
    assign o_frames   = fcnt;
    assign o_aux_size = AUX_DEPTH - front;
    assign o_gbase    = gbase;
    assign o_tos      = (dcnt > 0) ? stk[dcnt-1] : 64'd0;

    function automatic t_status room(int need, int push);
        if (dcnt < need) return ST_UNDER;
        if (dcnt - need + push > DATA_DEPTH) return ST_OVER;
        return ST_OK;
    endfunction

    function automatic logic [63:0] sdiv(logic [63:0] b, logic [63:0] a, logic want_q);
        logic [63:0] mb, ma, mq, mr;
        mb = b[63] ? -b : b;
        ma = a[63] ? -a : a;
        mq = mb / ma;
        mr = mb % ma;
        if (want_q) return (b[63] != a[63]) ? -mq : mq;
        return b[63] ? -mr : mr;
    endfunction

    task automatic execute(input logic [7:0] op, input logic [7:0] p);
        t_outcome    o;
        t_status     st;
        t_kind       kind;
        logic [63:0] val, a, b, c, r;
        logic [15:0] npc;
        logic [7:0]  nch;
        int          idx;
        st   = ST_OK;
        kind = KD_NONE;
        val  = '0;
        npc  = pc + 16'd1;
        nch  = chunk;
        if (halted) begin
            o = '{hcode, pc, chunk, KD_NONE, 64'd0};
            outcome_q.push_back(o);
            return;
        end
        case (op)
            OP_TRAP: st = ST_TRAP;
            OP_EXIT: begin
                st = room(1, 1);
                if (st == ST_OK) begin
                    st = ST_EXIT;
                    kind = KD_EXIT;
                    val = stk[dcnt-1];
                end
            end
            OP_PRN, OP_PRC: begin
                st = room(1, 0);
                if (st == ST_OK) begin
                    dcnt--;
                    val = stk[dcnt];
                    kind = (op == OP_PRN) ? KD_DEC : KD_CHAR;
                    if (kind == KD_CHAR) val = {56'd0, val[7:0]};
                end
            end
            OP_NOP: ;
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_SHL, OP_SHR, OP_SAR, OP_AND, OP_OR: begin
                st = room(2, 1);
                if (st == ST_OK) begin
                    a = stk[dcnt-1];
                    b = stk[dcnt-2];
                    r = '0;
                    case (op)
                        OP_ADD: r = b + a;
                        OP_SUB: r = b - a;
                        OP_MUL: r = b * a;
                        OP_DIV, OP_MOD: begin
                            if (a == 0) st = ST_DIVZ;
                            else r = sdiv(b, a, op == OP_DIV);
                        end
                        OP_SHL: r = b << a[5:0];
                        OP_SHR: r = b >> a[5:0];
                        OP_SAR: r = $signed(b) >>> a[5:0];
                        OP_AND: r = b & a;
                        default: r = b | a;
                    endcase
                    if (st == ST_OK) begin
                        dcnt--;
                        stk[dcnt-1] = r;
                    end
                end
            end
            OP_LNOT, OP_NOT, OP_NEG: begin
                st = room(1, 1);
                if (st == ST_OK) begin
                    a = stk[dcnt-1];
                    if (op == OP_LNOT) a = (a == 0) ? 64'd1 : 64'd0;
                    else if (op == OP_NOT) a = ~a;
                    else a = -a;
                    stk[dcnt-1] = a;
                end
            end
            OP_IMM: begin
                st = room(0, 1);
                if (st == ST_OK) begin
                    stk[dcnt] = {{56{p[7]}}, p};
                    dcnt++;
                end
            end
            OP_GLD, OP_GST: begin
                idx = int'($signed(gbase)) + int'($signed(p));
                st = (op == OP_GLD) ? room(0, 1) : room(1, 0);
                if (st == ST_OK) begin
                    if (idx < 0 || idx >= GLOBAL_DEPTH) st = ST_INDEX;
                    else if (op == OP_GLD) begin
                        stk[dcnt] = glb[idx];
                        dcnt++;
                    end else begin
                        dcnt--;
                        glb[idx] = stk[dcnt];
                    end
                end
            end
            OP_GBI: gbase = gbase + {p[7], p};
            OP_AST, OP_ALD, OP_AMV: begin
                st = (op == OP_AST) ? room(1, 0) : room(0, 1);
                if (st == ST_OK) begin
                    if (int'(p) >= AUX_DEPTH - front) st = ST_INDEX;
                    else if (op == OP_AST) begin
                        dcnt--;
                        aux[front+p] = stk[dcnt];
                    end else begin
                        stk[dcnt] = aux[front+p];
                        dcnt++;
                        if (op == OP_AMV) aux[front+p] = '0;
                    end
                end
            end
            OP_DUP: begin
                st = room(1, 2);
                if (st == ST_OK) begin
                    stk[dcnt] = stk[dcnt-1];
                    dcnt++;
                end
            end
            OP_DUP2: begin
                st = room(2, 4);
                if (st == ST_OK) begin
                    a = stk[dcnt-1];
                    b = stk[dcnt-2];
                    stk[dcnt] = b;
                    stk[dcnt+1] = a;
                    dcnt += 2;
                end
            end
            OP_ROT2: begin
                st = room(2, 2);
                if (st == ST_OK) begin
                    a = stk[dcnt-1];
                    stk[dcnt-1] = stk[dcnt-2];
                    stk[dcnt-2] = a;
                end
            end
            OP_ROT3: begin
                st = room(3, 3);
                if (st == ST_OK) begin
                    a = stk[dcnt-1];
                    b = stk[dcnt-2];
                    c = stk[dcnt-3];
                    stk[dcnt-3] = b;
                    stk[dcnt-2] = a;
                    stk[dcnt-1] = c;
                end
            end
            OP_DROP: begin
                st = room(1, 0);
                if (st == ST_OK) dcnt--;
            end
            OP_JMP: npc = pc + {{8{p[7]}}, p};
            OP_JNZ: begin
                st = room(1, 0);
                if (st == ST_OK) begin
                    dcnt--;
                    if (stk[dcnt] != 0) npc = pc + {{8{p[7]}}, p};
                end
            end
            OP_CALL: begin
                if (fcnt >= CALL_DEPTH || front < AUX_WINDOW) st = ST_CALL;
                else begin
                    frm[fcnt] = '{pc, chunk, gbase};
                    fcnt++;
                    front -= AUX_WINDOW;
                    for (int i = 0; i < AUX_WINDOW; i++) aux[front+i] = '0;
                    npc = '0;
                    nch = p;
                    gbase = '0;
                end
            end
            OP_RET: begin
                if (fcnt == 0) st = ST_CALL;
                else begin
                    fcnt--;
                    npc = frm[fcnt].pc + 16'd1;
                    nch = frm[fcnt].chunk;
                    gbase = frm[fcnt].base;
                    front = (front + AUX_WINDOW > AUX_DEPTH) ? AUX_DEPTH : front + AUX_WINDOW;
                end
            end
            default: st = ST_BADOP;
        endcase
        if (st != ST_OK) begin
            halted = 1'b1;
            hcode = st;
            if (st != ST_EXIT) begin
                kind = KD_NONE;
                val = '0;
            end
        end else begin
            pc = npc;
            chunk = nch;
        end
        o = '{st, pc, chunk, kind, val};
        outcome_q.push_back(o);
    endtask

    always @(posedge i_clk) begin
        t_outcome    e;
        logic [3:0]  a_st;
        logic [15:0] a_pc;
        logic [7:0]  a_ch;
        logic [63:0] a_val;
        if (!i_rst_n) begin
            for (int i = 0; i < AUX_DEPTH; i++) aux[i] = '0;
            for (int i = 0; i < GLOBAL_DEPTH; i++) glb[i] = '0;
            dcnt = 0;
            fcnt = 0;
            front = AUX_FRONT_RST;
            pc = '0;
            chunk = 8'd1;
            gbase = '0;
            halted = 1'b0;
            hcode = ST_OK;
            outcome_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                a_st  = i_m_tdata[3:0];
                a_pc  = i_m_tdata[19:4];
                a_ch  = i_m_tdata[27:20];
                a_val = i_m_tdata[91:28];
                if (outcome_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result beat status=%0d pc=%h", a_st, a_pc);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = outcome_q[0];
                    outcome_q.delete(0);
                    if (a_st !== e.status || a_pc !== e.pc || a_ch !== e.chunk ||
                        i_m_tuser !== e.kind || a_val !== e.value) begin
                        if (o_fail_count < 10) begin
                            $display("mismatch exp st=%0d pc=%h ch=%h kd=%0d v=%h",
                                     e.status, e.pc, e.chunk, e.kind, e.value);
                            $display("         got st=%0d pc=%h ch=%h kd=%0d v=%h",
                                     a_st, a_pc, a_ch, i_m_tuser, a_val);
                        end
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) execute(i_s_tdata[7:0], i_s_tdata[15:8]);
        end
    end
endmodule

[verif/tb_stack_machine_execute_unit.sv]
// testbench top for the stack machine execute unit: drives instruction beats that
// stay clear of faults, ends with one chosen fault and some halted beats
// depends on smeu_pkg, smeu_result_checker and the execute unit rtl
`timescale 1ns / 1ps

module tb_stack_machine_execute_unit;
    import smeu_pkg::*;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;
    int                     fails, pending, depth, frames, aux_size;
    logic [8:0]             gbase;
    logic [63:0]            tos;
    logic                   no_gaps;

    stack_machine_execute_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready), .s_axis_tdata(s_tdata),
        .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready),
        .m_axis_tdata(m_tdata), .m_axis_tuser(m_tuser)
    );

    smeu_result_checker i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata), .i_m_tuser(m_tuser),
        .o_fail_count(fails), .o_pending(pending), .o_depth(depth), .o_frames(frames),
        .o_aux_size(aux_size), .o_gbase(gbase), .o_tos(tos)
    );

    localparam logic [7:0] SAFE_OPS[30] = '{
        OP_PRN, OP_PRC, OP_NOP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_SHL, OP_SHR,
        OP_SAR, OP_AND, OP_OR, OP_LNOT, OP_NOT, OP_NEG, OP_IMM, OP_GLD, OP_GST, OP_GBI,
        OP_AST, OP_ALD, OP_AMV, OP_DUP, OP_DUP2, OP_ROT2, OP_ROT3, OP_DROP, OP_JMP, OP_JNZ
    };

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("tb_stack_machine_execute_unit: FAIL");
        $finish;
    end

    function automatic int gap_len();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic known_op(logic [7:0] op);
        foreach (SAFE_OPS[i]) if (SAFE_OPS[i] == op) return 1'b1;
        return op == OP_TRAP || op == OP_EXIT || op == OP_CALL || op == OP_RET;
    endfunction

    // called at a falling edge; valid stays high into the next beat when there is no gap
    task automatic send_beat(input logic [7:0] op, input logic [7:0] p);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {p, op};
        while (!s_tready) @(negedge i_clk);
        @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // rewrites an instruction that would fault into one that cannot
    task automatic send_clean(input logic [7:0] op_in, input logic [7:0] p_in);
        logic [7:0] op, p;
        int         need, push, lo, hi, gb;
        op = op_in;
        p  = p_in;
        need = 0;
        push = 0;
        case (op)
            OP_PRN, OP_PRC, OP_GST, OP_AST, OP_DROP, OP_JNZ: need = 1;
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_SHL, OP_SHR, OP_SAR,
            OP_AND, OP_OR: begin need = 2; push = 1; end
            OP_LNOT, OP_NOT, OP_NEG: begin need = 1; push = 1; end
            OP_IMM, OP_GLD, OP_ALD, OP_AMV: push = 1;
            OP_DUP: begin need = 1; push = 2; end
            OP_DUP2: begin need = 2; push = 4; end
            OP_ROT2: begin need = 2; push = 2; end
            OP_ROT3: begin need = 3; push = 3; end
            default: ;
        endcase
        gb = int'($signed(gbase));
        if (depth < need) op = OP_IMM;
        else if (depth - need + push > DATA_DEPTH) op = OP_DROP;
        else if ((op == OP_DIV || op == OP_MOD) && tos == 0) op = OP_ADD;
        else if (op == OP_GLD || op == OP_GST) begin
            lo = (gb - 128 > 0) ? gb - 128 : 0;
            hi = (gb + 127 < GLOBAL_DEPTH - 1) ? gb + 127 : GLOBAL_DEPTH - 1;
            if (lo > hi) begin
                op = OP_GBI;
                p = (gb > 0) ? 8'h80 : 8'h7F;
            end else p = 8'($urandom_range(lo, hi) - gb);
        end else if (op == OP_AST || op == OP_ALD || op == OP_AMV) begin
            if (int'(p) >= aux_size) p = 8'($urandom_range(0, aux_size - 1));
        end else if (op == OP_CALL && (frames >= CALL_DEPTH || AUX_DEPTH - aux_size < AUX_WINDOW))
            op = OP_RET;
        else if (op == OP_RET && frames == 0) op = OP_CALL;
        send_beat(op, p);
    endtask

    initial begin
        forever begin
            @(negedge i_clk);
            if (no_gaps) m_tready <= 1'b1;
            else if ($urandom_range(0, 99) < 3) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(10, 60)) @(negedge i_clk);
            end else m_tready <= ($urandom_range(0, 99) < 70);
        end
    end

    initial begin
        logic [7:0] d_op[$], d_par[$], op;
        int         n, pick;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        no_gaps  = 1'b0;
        i_rst_n  = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n  = 1'b1;

        d_op = '{OP_IMM, OP_IMM, OP_ADD, OP_PRN, OP_IMM, OP_IMM, OP_SHL, OP_DUP, OP_IMM,
                 OP_DIV, OP_PRN, OP_NEG, OP_IMM, OP_SAR, OP_PRC, OP_IMM, OP_GST, OP_GBI,
                 OP_GLD, OP_CALL, OP_AST, OP_AMV, OP_RET, OP_JMP, OP_JNZ};
        d_par = '{8'h7F, 8'h80, 8'h00, 8'h00, 8'h01, 8'h3F, 8'h00, 8'h00, 8'hFF,
                  8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h55, 8'h7F, 8'h7F,
                  8'h00, 8'hFF, 8'h0F, 8'h0F, 8'h00, 8'h80, 8'h7F};
        foreach (d_op[i]) send_clean(d_op[i], d_par[i]);

        for (n = 0; n < 2000; n++) begin
            if (n % 150 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 4) op = OP_CALL;
            else if (pick < 8) op = OP_RET;
            else op = SAFE_OPS[$urandom_range(0, 29)];
            send_clean(op, 8'($urandom));
        end
        no_gaps = 1'b0;

        case ($urandom_range(0, 7))
            0: send_beat(OP_TRAP, 8'($urandom));
            1: begin
                send_clean(OP_IMM, 8'($urandom));
                send_beat(OP_EXIT, 8'($urandom));
            end
            2: begin
                do op = 8'($urandom); while (known_op(op));
                send_beat(op, 8'($urandom));
            end
            3: begin
                while (depth > 0) send_clean(OP_DROP, 8'd0);
                send_beat(OP_DROP, 8'd0);
            end
            4: begin
                while (depth < DATA_DEPTH) send_clean(OP_IMM, 8'($urandom));
                send_beat(OP_IMM, 8'($urandom));
            end
            5: begin
                while (depth > 60) send_clean(OP_DROP, 8'd0);
                send_clean(OP_IMM, 8'($urandom));
                send_clean(OP_IMM, 8'd0);
                send_beat(($urandom_range(0, 1) == 0) ? OP_DIV : OP_MOD, 8'd0);
            end
            6: begin
                while (frames > 0) send_clean(OP_RET, 8'd0);
                send_beat(OP_RET, 8'd0);
            end
            default: begin
                while (depth >= DATA_DEPTH) send_clean(OP_DROP, 8'd0);
                send_beat(OP_ALD, 8'hFF);
            end
        endcase
        repeat (5) send_beat(8'($urandom), 8'($urandom));
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fails == 0) $display("tb_stack_machine_execute_unit: PASS");
        else $display("tb_stack_machine_execute_unit: FAIL");
        $finish;
    end
endmodule

[stack_machine_execute_unit.f]
+incdir+rtl
rtl/smeu_pkg.sv
rtl/smeu_mdu.sv
rtl/smeu_dpath.sv
rtl/smeu_ctrl.sv
rtl/stack_machine_execute_unit.sv
verif/smeu_result_checker.sv
verif/tb_stack_machine_execute_unit.sv
